/* src/rlfp_pkg.sv */
package rlfp_pkg;

   // number of steps in one record program
   localparam int ProgLen = 10;

   // field step operations
   localparam logic [2:0] OP_END        = 3'd0;
   localparam logic [2:0] OP_COPY_UNTIL = 3'd1;
   localparam logic [2:0] OP_COPY_REST  = 3'd2;
   localparam logic [2:0] OP_SKIP       = 3'd3;
   localparam logic [2:0] OP_NUMBER     = 3'd4;

   // record program slots
   localparam logic [2:0] SLOT_DOLLAR = 3'd0;
   localparam logic [2:0] SLOT_HASH   = 3'd1;
   localparam logic [2:0] SLOT_COLON  = 3'd2;
   localparam logic [2:0] SLOT_PLUS   = 3'd3;
   localparam logic [2:0] SLOT_BANG   = 3'd4;
   localparam logic [2:0] SLOT_LT     = 3'd5;
   localparam logic [2:0] SLOT_NONE   = 3'd7;

   // characters
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [1:0]         text_field;
      logic [7:0]         text_char;
      logic [7:0]         line_type;
      logic signed [63:0] num_one;
      logic signed [63:0] num_two;
      logic signed [63:0] num_three;
   } rsp_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] ch;
      logic [1:0] sel;
   } step_type;

   // step that takes the current character, and where the program stands after it
   typedef struct packed {
      logic [3:0] idx;
      logic [2:0] op;
      logic [1:0] sel;
   } act_type;

   function automatic logic [2:0] type_slot(logic [7:0] t);
      logic [2:0] s;
      unique case (t)
         CH_DOLLAR: s = SLOT_DOLLAR;
         CH_HASH:   s = SLOT_HASH;
         CH_COLON:  s = SLOT_COLON;
         CH_PLUS:   s = SLOT_PLUS;
         CH_BANG:   s = SLOT_BANG;
         CH_LT:     s = SLOT_LT;
         default:   s = SLOT_NONE;
      endcase
      return s;
   endfunction

   function automatic step_type mk(logic [2:0] op, logic [7:0] ch, logic [1:0] sel);
      step_type s;
      s.op  = op;
      s.ch  = ch;
      s.sel = sel;
      return s;
   endfunction

   // program table, one entry per record type and step
   function automatic step_type prog_step(logic [2:0] slot, logic [3:0] idx);
      step_type s;
      s = mk(OP_END, 8'd0, 2'd0);
      unique case (slot)
         SLOT_DOLLAR: begin
            unique case (idx)
               4'd0:    s = mk(OP_COPY_UNTIL, CH_SPACE, 2'd1);
               4'd1:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd2:    s = mk(OP_COPY_REST, 8'd0, 2'd2);
               default: s = mk(OP_END, 8'd0, 2'd0);
            endcase
         end
         SLOT_HASH: begin
            unique case (idx)
               4'd0:    s = mk(OP_COPY_UNTIL, CH_SPACE, 2'd1);
               4'd1:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd2:    s = mk(OP_NUMBER, 8'd0, 2'd0);
               default: s = mk(OP_END, 8'd0, 2'd0);
            endcase
         end
         SLOT_COLON: begin
            unique case (idx)
               4'd0:    s = mk(OP_COPY_UNTIL, CH_COLON, 2'd1);
               4'd1:    s = mk(OP_SKIP, CH_COLON, 2'd0);
               4'd2:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd3:    s = mk(OP_NUMBER, 8'd0, 2'd0);
               4'd4:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd5:    s = mk(OP_NUMBER, 8'd0, 2'd1);
               4'd6:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd7:    s = mk(OP_COPY_REST, 8'd0, 2'd2);
               default: s = mk(OP_END, 8'd0, 2'd0);
            endcase
         end
         SLOT_PLUS: begin
            unique case (idx)
               4'd0:    s = mk(OP_COPY_UNTIL, CH_SPACE, 2'd1);
               4'd1:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd2:    s = mk(OP_NUMBER, 8'd0, 2'd0);
               4'd3:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd4:    s = mk(OP_COPY_UNTIL, CH_SPACE, 2'd2);
               4'd5:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd6:    s = mk(OP_COPY_REST, 8'd0, 2'd3);
               default: s = mk(OP_END, 8'd0, 2'd0);
            endcase
         end
         SLOT_BANG: begin
            unique case (idx)
               4'd0:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd1:    s = mk(OP_NUMBER, 8'd0, 2'd0);
               4'd2:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd3:    s = mk(OP_NUMBER, 8'd0, 2'd1);
               4'd4:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd5:    s = mk(OP_COPY_UNTIL, CH_SPACE, 2'd1);
               4'd6:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd7:    s = mk(OP_NUMBER, 8'd0, 2'd2);
               default: s = mk(OP_END, 8'd0, 2'd0);
            endcase
         end
         SLOT_LT: begin
            unique case (idx)
               4'd0:    s = mk(OP_COPY_UNTIL, CH_GT, 2'd1);
               4'd1:    s = mk(OP_SKIP, CH_GT, 2'd0);
               4'd2:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd3:    s = mk(OP_NUMBER, 8'd0, 2'd0);
               4'd4:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd5:    s = mk(OP_NUMBER, 8'd0, 2'd1);
               4'd6:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd7:    s = mk(OP_NUMBER, 8'd0, 2'd2);
               4'd8:    s = mk(OP_SKIP, CH_SPACE, 2'd0);
               4'd9:    s = mk(OP_COPY_REST, 8'd0, 2'd2);
               default: s = mk(OP_END, 8'd0, 2'd0);
            endcase
         end
         default: s = mk(OP_END, 8'd0, 2'd0);
      endcase
      return s;
   endfunction

endpackage

/* src/rlfp_step_sel.sv */
module rlfp_step_sel (
   input  logic [2:0]       slot,
   input  logic [3:0]       step_idx,
   input  logic [7:0]       char_byte,
   output rlfp_pkg::act_type act
);

   // find the first step at or after the current one that takes the character;
   // each step decides from the character alone, so all steps are checked in parallel
   always_comb begin
      rlfp_pkg::step_type st;
      logic               takes;
      logic               found;
      found    = 1'b0;
      act.idx  = 4'(rlfp_pkg::ProgLen);
      act.op   = rlfp_pkg::OP_END;
      act.sel  = 2'd0;
      for (int i = 0; i < rlfp_pkg::ProgLen; i++) begin
         st = rlfp_pkg::prog_step(slot, 4'(i));
         unique case (st.op)
            rlfp_pkg::OP_COPY_UNTIL: takes = (char_byte != st.ch);
            rlfp_pkg::OP_COPY_REST:  takes = 1'b1;
            rlfp_pkg::OP_SKIP:       takes = (char_byte == st.ch);
            rlfp_pkg::OP_NUMBER:     takes = (char_byte != rlfp_pkg::CH_SPACE);
            default:                 takes = 1'b1;
         endcase
         if (!found && (4'(i) >= step_idx) && takes) begin
            found   = 1'b1;
            act.op  = st.op;
            act.sel = st.sel;
            // an end step finishes the program
            act.idx = (st.op == rlfp_pkg::OP_END) ? 4'(rlfp_pkg::ProgLen) : 4'(i);
         end
      end
   end

endmodule

/* src/rlfp_line_state.sv */
module rlfp_line_state (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  rlfp_pkg::req_type item,
   output logic              has_result,
   output rlfp_pkg::rsp_type result
);

   logic        at_line_start_ff, at_line_start_in;
   logic [7:0]  record_kind_ff, record_kind_in;
   logic [3:0]  step_index_ff, step_index_in;
   logic [63:0] accum_one_ff, accum_one_in;
   logic [63:0] accum_two_ff, accum_two_in;
   logic [63:0] accum_three_ff, accum_three_in;
   logic [2:0]  negative_flags_ff, negative_flags_in;

   logic [2:0]        slot;
   logic              active;
   logic              is_copy;
   logic [63:0]       acc_sel;
   logic [63:0]       acc_next;
   rlfp_pkg::act_type act;

   assign slot = rlfp_pkg::type_slot(record_kind_ff);

   rlfp_step_sel u_step_sel (
      .slot      (slot),
      .step_idx  (step_index_ff),
      .char_byte (item.char_byte),
      .act       (act)
   );

   assign active  = !item.end_of_line && !at_line_start_ff && (slot != rlfp_pkg::SLOT_NONE);
   assign is_copy = (act.op == rlfp_pkg::OP_COPY_UNTIL) || (act.op == rlfp_pkg::OP_COPY_REST);
   assign has_result = item.end_of_line || (active && is_copy);

   // pick the accumulator of the current number and add the next digit
   always_comb begin
      unique case (act.sel)
         2'd1:    acc_sel = accum_two_ff;
         2'd2:    acc_sel = accum_three_ff;
         default: acc_sel = accum_one_ff;
      endcase
   end
   assign acc_next = (acc_sel << 3) + (acc_sel << 1) + {56'd0, item.char_byte}
                     - {56'd0, rlfp_pkg::CH_ZERO};

   // build the result: a text transfer or the finished record
   always_comb begin
      result = '0;
      if (item.end_of_line) begin
         result.kind      = 1'b1;
         result.line_type = record_kind_ff;
         result.num_one   = negative_flags_ff[0] ? 64'd0 - accum_one_ff : accum_one_ff;
         result.num_two   = negative_flags_ff[1] ? 64'd0 - accum_two_ff : accum_two_ff;
         result.num_three = negative_flags_ff[2] ? 64'd0 - accum_three_ff : accum_three_ff;
      end else begin
         result.text_field = act.sel;
         result.text_char  = item.char_byte;
      end
   end

   // advance the line state on each transfer
   always_comb begin
      at_line_start_in  = at_line_start_ff;
      record_kind_in    = record_kind_ff;
      step_index_in     = step_index_ff;
      accum_one_in      = accum_one_ff;
      accum_two_in      = accum_two_ff;
      accum_three_in    = accum_three_ff;
      negative_flags_in = negative_flags_ff;
      if (fire) begin
         priority if (item.end_of_line) begin
            at_line_start_in  = 1'b1;
            record_kind_in    = 8'd0;
            step_index_in     = 4'd0;
            accum_one_in      = 64'd0;
            accum_two_in      = 64'd0;
            accum_three_in    = 64'd0;
            negative_flags_in = 3'd0;
         end else if (at_line_start_ff) begin
            at_line_start_in = 1'b0;
            record_kind_in   = (rlfp_pkg::type_slot(item.char_byte) != rlfp_pkg::SLOT_NONE)
                               ? item.char_byte : 8'd0;
            step_index_in    = 4'd0;
         end else if (active) begin
            step_index_in = act.idx;
            if (act.op == rlfp_pkg::OP_NUMBER) begin
               if (item.char_byte == rlfp_pkg::CH_MINUS) begin
                  unique case (act.sel)
                     2'd0:    negative_flags_in[0] = 1'b1;
                     2'd1:    negative_flags_in[1] = 1'b1;
                     2'd2:    negative_flags_in[2] = 1'b1;
                     default: negative_flags_in = negative_flags_ff;
                  endcase
               end else begin
                  unique case (act.sel)
                     2'd0:    accum_one_in   = acc_next;
                     2'd1:    accum_two_in   = acc_next;
                     2'd2:    accum_three_in = acc_next;
                     default: accum_one_in   = accum_one_ff;
                  endcase
               end
            end
         end else begin
            step_index_in = step_index_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff  <= 1'b1;
         record_kind_ff    <= 8'd0;
         step_index_ff     <= 4'd0;
         accum_one_ff      <= 64'd0;
         accum_two_ff      <= 64'd0;
         accum_three_ff    <= 64'd0;
         negative_flags_ff <= 3'd0;
      end else begin
         at_line_start_ff  <= at_line_start_in;
         record_kind_ff    <= record_kind_in;
         step_index_ff     <= step_index_in;
         accum_one_ff      <= accum_one_in;
         accum_two_ff      <= accum_two_in;
         accum_three_ff    <= accum_three_in;
         negative_flags_ff <= negative_flags_in;
      end
   end

`ifndef SYNTHESIS
   a_line_start_clean: assert property (@(posedge clock) disable iff (reset)
      at_line_start_ff |-> (step_index_ff == 4'd0) && (negative_flags_ff == 3'd0)
                           && (accum_one_ff == 64'd0) && (accum_three_ff == 64'd0))
      else $error("line state not cleared at line start");

   a_invalid_no_numbers: assert property (@(posedge clock) disable iff (reset)
      (record_kind_ff == 8'd0) |-> (accum_two_ff == 64'd0) && (negative_flags_ff == 3'd0))
      else $error("invalid line collected a number");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      fire && !item.end_of_line && !at_line_start_ff
      |=> step_index_ff >= $past(step_index_ff))
      else $error("program step moved backward");
`endif

endmodule

/* src/record_line_field_parser.sv */
// Line parser for a character stream.
// req channel: one character per transfer (char_byte), or an end-of-line
// marker (end_of_line set, char_byte ignored). The first character of a
// line selects the record type; later characters run through that type's
// program of field steps.
// rsp channel: a text transfer (kind 0) for each character copied into a
// text field, and one record transfer (kind 1) per end-of-line marker with
// the type and three signed 64-bit numbers. Characters that are skipped or
// go into a number produce no transfer.
// Path: a request transfer loads the input register; its result, if any,
// loads the result register, which drives rsp_valid, once that register is
// free (empty or being taken). Throughput: one character per cycle while
// no result waits on rsp_stall, set by the combinational step search and
// 64-bit digit accumulate that update the line state.
// Reset clears the line state; the next character is a type character.
// When rsp_stall holds a result, the input register still drains items that
// produce no result; an item that needs the result register waits and
// raises req_stall.
module record_line_field_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rlfp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rlfp_pkg::rsp_type rsp_payload
);

   logic              in_valid_ff, in_valid_in;
   rlfp_pkg::req_type in_ff;
   logic              out_valid_ff, out_valid_in;
   rlfp_pkg::rsp_type out_ff;

   logic              out_free;
   logic              consume;
   logic              accept;
   logic              has_result;
   rlfp_pkg::rsp_type result;

   rlfp_line_state u_line_state (
      .clock      (clock),
      .reset      (reset),
      .fire       (consume),
      .item       (in_ff),
      .has_result (has_result),
      .result     (result)
   );

   // drain the input register when it has no result or its result has a place to go
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign consume   = in_valid_ff && (!has_result || out_free);
   assign req_stall = in_valid_ff && !consume;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !consume);
   assign out_valid_in = out_free ? (consume && has_result) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // load payload registers on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_payload;
      end
      if (consume && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   a_text_field_set: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.kind |-> out_ff.text_field != 2'd0)
      else $error("text transfer without a field");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !consume |=> in_valid_ff && $stable(in_ff))
      else $error("waiting item lost");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;

   localparam int CycleLimit = 200000;
   localparam int RandomItems = 800;
   localparam int TailItems = 60;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   rlfp_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rlfp_pkg::rsp_type rsp_payload;

   // character transfers still to be sent, and records/characters still owed
   rlfp_pkg::req_type char_stream [$];
   rlfp_pkg::rsp_type due_rsp [$];
   logic [7:0]        line_buf [$];

   // line state of the parser as the testbench sees it
   logic        line_start = 1'b1;
   logic [7:0]  cur_type = '0;
   int unsigned step_at = 0;
   logic [63:0] acc [3] = '{default: '0};
   logic [2:0]  neg = '0;

   int   fail_count = 0;
   int   cycles = 0;
   logic jitter_on = 1'b1;
   logic tail = 1'b0;
   int   gap_left = 0;
   int   stall_left = 0;

   record_line_field_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic bit is_record_type(logic [7:0] c);
      return c == rlfp_pkg::CH_DOLLAR || c == rlfp_pkg::CH_HASH || c == rlfp_pkg::CH_COLON
          || c == rlfp_pkg::CH_PLUS || c == rlfp_pkg::CH_BANG || c == rlfp_pkg::CH_LT;
   endfunction

   // field program of each record type
   function automatic rlfp_pkg::step_type line_step(logic [7:0] rec, int unsigned at);
      rlfp_pkg::step_type prog [rlfp_pkg::ProgLen];
      foreach (prog[i]) prog[i] = '{rlfp_pkg::OP_END, 8'd0, 2'd0};
      case (rec)
         rlfp_pkg::CH_DOLLAR: begin
            prog[0] = '{rlfp_pkg::OP_COPY_UNTIL, rlfp_pkg::CH_SPACE, 2'd1};
            prog[1] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[2] = '{rlfp_pkg::OP_COPY_REST, 8'd0, 2'd2};
         end
         rlfp_pkg::CH_HASH: begin
            prog[0] = '{rlfp_pkg::OP_COPY_UNTIL, rlfp_pkg::CH_SPACE, 2'd1};
            prog[1] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[2] = '{rlfp_pkg::OP_NUMBER, 8'd0, 2'd0};
         end
         rlfp_pkg::CH_COLON: begin
            prog[0] = '{rlfp_pkg::OP_COPY_UNTIL, rlfp_pkg::CH_COLON, 2'd1};
            prog[1] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_COLON, 2'd0};
            prog[2] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[3] = '{rlfp_pkg::OP_NUMBER, 8'd0, 2'd0};
            prog[4] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[5] = '{rlfp_pkg::OP_NUMBER, 8'd0, 2'd1};
            prog[6] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[7] = '{rlfp_pkg::OP_COPY_REST, 8'd0, 2'd2};
         end
         rlfp_pkg::CH_PLUS: begin
            prog[0] = '{rlfp_pkg::OP_COPY_UNTIL, rlfp_pkg::CH_SPACE, 2'd1};
            prog[1] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[2] = '{rlfp_pkg::OP_NUMBER, 8'd0, 2'd0};
            prog[3] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[4] = '{rlfp_pkg::OP_COPY_UNTIL, rlfp_pkg::CH_SPACE, 2'd2};
            prog[5] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[6] = '{rlfp_pkg::OP_COPY_REST, 8'd0, 2'd3};
         end
         rlfp_pkg::CH_BANG: begin
            prog[0] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[1] = '{rlfp_pkg::OP_NUMBER, 8'd0, 2'd0};
            prog[2] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[3] = '{rlfp_pkg::OP_NUMBER, 8'd0, 2'd1};
            prog[4] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[5] = '{rlfp_pkg::OP_COPY_UNTIL, rlfp_pkg::CH_SPACE, 2'd1};
            prog[6] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[7] = '{rlfp_pkg::OP_NUMBER, 8'd0, 2'd2};
         end
         rlfp_pkg::CH_LT: begin
            prog[0] = '{rlfp_pkg::OP_COPY_UNTIL, rlfp_pkg::CH_GT, 2'd1};
            prog[1] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_GT, 2'd0};
            prog[2] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[3] = '{rlfp_pkg::OP_NUMBER, 8'd0, 2'd0};
            prog[4] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[5] = '{rlfp_pkg::OP_NUMBER, 8'd0, 2'd1};
            prog[6] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[7] = '{rlfp_pkg::OP_NUMBER, 8'd0, 2'd2};
            prog[8] = '{rlfp_pkg::OP_SKIP, rlfp_pkg::CH_SPACE, 2'd0};
            prog[9] = '{rlfp_pkg::OP_COPY_REST, 8'd0, 2'd2};
         end
         default: ;
      endcase
      return prog[at];
   endfunction

   // advance the line state by one transfer and queue what it owes
   function automatic void parse_step(rlfp_pkg::req_type item);
      rlfp_pkg::step_type s;
      rlfp_pkg::rsp_type  r;
      logic [7:0]         c;
      c = item.char_byte;
      r = '0;
      if (item.end_of_line) begin
         r.kind      = 1'b1;
         r.line_type = cur_type;
         r.num_one   = neg[0] ? -acc[0] : acc[0];
         r.num_two   = neg[1] ? -acc[1] : acc[1];
         r.num_three = neg[2] ? -acc[2] : acc[2];
         due_rsp     = {due_rsp, r};
         line_start  = 1'b1;
         cur_type    = '0;
         step_at     = 0;
         acc         = '{default: '0};
         neg         = '0;
         return;
      end
      if (line_start) begin
         line_start = 1'b0;
         cur_type   = is_record_type(c) ? c : 8'd0;
         step_at    = 0;
         return;
      end
      // invalid line: drop everything up to end of line
      if (cur_type == 8'd0) return;
      while (step_at < rlfp_pkg::ProgLen) begin
         s = line_step(cur_type, step_at);
         case (s.op)
            rlfp_pkg::OP_COPY_UNTIL, rlfp_pkg::OP_COPY_REST: begin
               if (s.op == rlfp_pkg::OP_COPY_UNTIL && c == s.ch) begin
                  step_at++;
               end else begin
                  r.text_field = s.sel;
                  r.text_char  = c;
                  due_rsp      = {due_rsp, r};
                  return;
               end
            end
            rlfp_pkg::OP_SKIP: begin
               if (c == s.ch) return;
               step_at++;
            end
            rlfp_pkg::OP_NUMBER: begin
               if (c != rlfp_pkg::CH_SPACE) begin
                  // any byte but minus counts as a digit, wrapping at 64 bits
                  if (c == rlfp_pkg::CH_MINUS) neg[s.sel] = 1'b1;
                  else acc[s.sel] = acc[s.sel] * 64'd10 + {56'd0, c}
                                    - {56'd0, rlfp_pkg::CH_ZERO};
                  return;
               end
               step_at++;
            end
            default: begin
               step_at = rlfp_pkg::ProgLen;
               return;
            end
         endcase
      end
   endfunction

   // line building
   function automatic void line_add(logic [7:0] c);
      line_buf = {line_buf, c};
   endfunction

   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++) line_add(s[i]);
   endfunction

   function automatic void put_digit();
      line_add(8'(rlfp_pkg::CH_ZERO + $urandom_range(0, 9)));
   endfunction

   function automatic void put_text(logic [7:0] stop, int unsigned max_len);
      logic [7:0] c;
      int unsigned n;
      n = $urandom_range(0, max_len);
      repeat (n) begin
         c = 8'($urandom_range(0, 255));
         if (c == stop) c = c ^ 8'h01;
         line_add(c);
      end
   endfunction

   function automatic void put_run(logic [7:0] ch);
      repeat ($urandom_range(1, 3)) line_add(ch);
   endfunction

   function automatic void put_number();
      logic [7:0] c;
      int unsigned mode;
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
         if ($urandom_range(0, 1)) line_add(rlfp_pkg::CH_MINUS);
         repeat ($urandom_range(1, 4)) put_digit();
      end else if (mode == 6) begin
         // 15 to 25 digits, so the longer ones wrap
         if ($urandom_range(0, 1)) line_add(rlfp_pkg::CH_MINUS);
         repeat ($urandom_range(15, 25)) put_digit();
      end else if (mode == 7) begin
         // most negative value, negated onto itself
         if ($urandom_range(0, 3) != 0) line_add(rlfp_pkg::CH_MINUS);
         put_str("9223372036854775808");
      end else if (mode == 8) begin
         // unchecked non-digits
         repeat ($urandom_range(1, 4)) begin
            c = 8'($urandom_range(0, 255));
            if (c == rlfp_pkg::CH_SPACE) c = rlfp_pkg::CH_ZERO;
            line_add(c);
         end
      end else begin
         // minus signs scattered among digits
         repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 2) == 0) line_add(rlfp_pkg::CH_MINUS);
            else put_digit();
         end
      end
   endfunction

   function automatic void finish_line(bit allow_cut);
      rlfp_pkg::req_type item;
      int unsigned keep;
      keep = line_buf.size();
      if (allow_cut && $urandom_range(0, 9) == 0) keep = $urandom_range(0, line_buf.size());
      for (int unsigned i = 0; i < keep; i++) begin
         item.char_byte   = line_buf[i];
         item.end_of_line = 1'b0;
         char_stream      = {char_stream, item};
      end
      item.char_byte   = 8'($urandom_range(0, 255));
      item.end_of_line = 1'b1;
      char_stream      = {char_stream, item};
      line_buf.delete();
   endfunction

   function automatic void put_random_line();
      logic [7:0] t;
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         // empty line
      end else if (pick == 1) begin
         // invalid type character followed by noise
         do t = 8'($urandom_range(0, 255)); while (is_record_type(t));
         line_add(t);
         put_text(rlfp_pkg::CH_SPACE, 6);
      end else begin
         case ($urandom_range(0, 5))
            0: t = rlfp_pkg::CH_DOLLAR;
            1: t = rlfp_pkg::CH_HASH;
            2: t = rlfp_pkg::CH_COLON;
            3: t = rlfp_pkg::CH_PLUS;
            4: t = rlfp_pkg::CH_BANG;
            default: t = rlfp_pkg::CH_LT;
         endcase
         line_add(t);
         if (pick == 2) begin
            // valid type, random body
            repeat ($urandom_range(0, 8)) line_add(8'($urandom_range(0, 255)));
         end else begin
            case (t)
               rlfp_pkg::CH_DOLLAR: begin
                  put_text(rlfp_pkg::CH_SPACE, 4); put_run(rlfp_pkg::CH_SPACE);
                  put_text(rlfp_pkg::CH_SPACE, 5);
               end
               rlfp_pkg::CH_HASH: begin
                  put_text(rlfp_pkg::CH_SPACE, 4); put_run(rlfp_pkg::CH_SPACE);
                  put_number();
               end
               rlfp_pkg::CH_COLON: begin
                  put_text(rlfp_pkg::CH_COLON, 4); put_run(rlfp_pkg::CH_COLON);
                  put_run(rlfp_pkg::CH_SPACE); put_number(); put_run(rlfp_pkg::CH_SPACE);
                  put_number(); put_run(rlfp_pkg::CH_SPACE);
                  put_text(rlfp_pkg::CH_SPACE, 5);
               end
               rlfp_pkg::CH_PLUS: begin
                  put_text(rlfp_pkg::CH_SPACE, 4); put_run(rlfp_pkg::CH_SPACE);
                  put_number(); put_run(rlfp_pkg::CH_SPACE);
                  put_text(rlfp_pkg::CH_SPACE, 4); put_run(rlfp_pkg::CH_SPACE);
                  put_text(rlfp_pkg::CH_SPACE, 5);
               end
               rlfp_pkg::CH_BANG: begin
                  put_run(rlfp_pkg::CH_SPACE); put_number(); put_run(rlfp_pkg::CH_SPACE);
                  put_number(); put_run(rlfp_pkg::CH_SPACE);
                  put_text(rlfp_pkg::CH_SPACE, 4); put_run(rlfp_pkg::CH_SPACE);
                  put_number();
               end
               default: begin
                  put_text(rlfp_pkg::CH_GT, 4); put_run(rlfp_pkg::CH_GT);
                  put_run(rlfp_pkg::CH_SPACE); put_number(); put_run(rlfp_pkg::CH_SPACE);
                  put_number(); put_run(rlfp_pkg::CH_SPACE); put_number();
                  put_run(rlfp_pkg::CH_SPACE); put_text(rlfp_pkg::CH_SPACE, 5);
               end
            endcase
            // a space and extra characters at the end of the line
            if ($urandom_range(0, 3) == 0) begin
               line_add(rlfp_pkg::CH_SPACE);
               repeat ($urandom_range(1, 3)) line_add(8'($urandom_range(0, 255)));
            end
         end
      end
      finish_line(1'b1);
   endfunction

   // stimulus, reset and end of run
   initial begin
      finish_line(1'b0);
      line_add(8'hFF); put_str("a"); finish_line(1'b0);
      put_str("$a  "); line_add(8'hFF); line_add(8'h00);
      finish_line(1'b0);
      put_str("# -7"); finish_line(1'b0);
      put_str("! --9"); finish_line(1'b0);
      put_str(":k:2"); finish_line(1'b0);
      put_str("+x 1 y z"); finish_line(1'b0);
      put_str("<>5"); finish_line(1'b0);
      while (char_stream.size() < RandomItems + 35) put_random_line();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (char_stream.size() != 0 || req_valid || due_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // cycle limit; pick quiet or busy windows for idling
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 64 == 0) jitter_on <= $urandom_range(0, 3) != 0;
      if (cycles >= CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // request driver: hold a stalled transfer, insert idle bursts
   always @(posedge clock) begin
      rlfp_pkg::req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (char_stream.size() == 0) begin
            req_valid <= 1'b0;
         end else if (jitter_on && !tail && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else begin
            item = char_stream.pop_front();
            parse_step(item);
            req_payload <= item;
            req_valid   <= 1'b1;
         end
         tail <= char_stream.size() < TailItems;
      end
   end

   function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // result monitor: check each transfer, drive stall bursts
   always @(posedge clock) begin
      rlfp_pkg::rsp_type want;
      bit                ok;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_rsp.size() == 0) begin
               $error("result with nothing expected: %h", rsp_payload);
               fail_count++;
            end else begin
               want = due_rsp.pop_front();
               ok = field_ok("kind", 64'(want.kind), 64'(rsp_payload.kind));
               ok &= field_ok("text_field", 64'(want.text_field),
                              64'(rsp_payload.text_field));
               ok &= field_ok("text_char", 64'(want.text_char), 64'(rsp_payload.text_char));
               ok &= field_ok("line_type", 64'(want.line_type), 64'(rsp_payload.line_type));
               ok &= field_ok("num_one", want.num_one, rsp_payload.num_one);
               ok &= field_ok("num_two", want.num_two, rsp_payload.num_two);
               ok &= field_ok("num_three", want.num_three, rsp_payload.num_three);
               if (!ok) fail_count++;
            end
         end
         if (jitter_on && !tail && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 3);
         if (stall_left > 0 && !tail) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = 0;
         end
      end
   end

endmodule

/* sim.f */
src/rlfp_pkg.sv
src/rlfp_step_sel.sv
src/rlfp_line_state.sv
src/record_line_field_parser.sv
tb/tb_top.sv
